/* rtl/evh_pkg.sv */
// shared constants and register codes for the energy voice activity detector
`default_nettype none
package evh_pkg;

  localparam int MAX_FRAME_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int LVL_W      = 15;
  localparam int HLIM_W     = 10;
  localparam int HCNT_W     = 11;
  localparam int FLEN_W     = 11;
  localparam int CNT_W      = 11;
  localparam int STATE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ONSET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HANG_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 3'd4;

  localparam logic [STATE_W-1:0] ST_SILENCE = 2'd0;
  localparam logic [STATE_W-1:0] ST_SPEECH  = 2'd1;
  localparam logic [STATE_W-1:0] ST_ENDING  = 2'd2;

  localparam logic [LVL_W-1:0]  ONSET_RST     = 15'd400;
  localparam logic [LVL_W-1:0]  OFFSET_RST    = 15'd50;
  localparam logic [LVL_W-1:0]  RECOVER_RST   = 15'd100;
  localparam logic [HLIM_W-1:0] HANG_LIM_RST  = 10'd10;
  localparam logic [FLEN_W-1:0] FRAME_LEN_RST = 11'd400;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [HCNT_W-1:0] HCNT_MAX = {HCNT_W{1'b1}};

endpackage
`default_nettype wire

/* rtl/evh_thresh.sv */
// squared threshold times frame length products, two pipelined multiplies
`default_nettype none
module evh_thresh #(
  parameter int MAX_FRAME = evh_pkg::MAX_FRAME_DEF,
  parameter int LEN_W     = $clog2(MAX_FRAME + 1),
  parameter int PROD_W    = 2 * evh_pkg::LVL_W + LEN_W
) (
  input  wire logic                      clk,
  input  wire logic [evh_pkg::LVL_W-1:0] onset_level,
  input  wire logic [evh_pkg::LVL_W-1:0] offset_level,
  input  wire logic [evh_pkg::LVL_W-1:0] recover_level,
  input  wire logic [LEN_W-1:0]          len_eff,
  output logic      [PROD_W-1:0]         onset_prod,
  output logic      [PROD_W-1:0]         offset_prod,
  output logic      [PROD_W-1:0]         recover_prod
);

  localparam int SQ_W = 2 * evh_pkg::LVL_W;

  logic [SQ_W-1:0]  onset_sq;
  logic [SQ_W-1:0]  offset_sq;
  logic [SQ_W-1:0]  recover_sq;
  logic [LEN_W-1:0] len_q;

  always_ff @(posedge clk) begin
    onset_sq   <= SQ_W'(onset_level) * SQ_W'(onset_level);
    offset_sq  <= SQ_W'(offset_level) * SQ_W'(offset_level);
    recover_sq <= SQ_W'(recover_level) * SQ_W'(recover_level);
    len_q      <= len_eff;
  end

  always_ff @(posedge clk) begin
    onset_prod   <= PROD_W'(onset_sq) * PROD_W'(len_q);
    offset_prod  <= PROD_W'(offset_sq) * PROD_W'(len_q);
    recover_prod <= PROD_W'(recover_sq) * PROD_W'(len_q);
  end

endmodule
`default_nettype wire

/* rtl/energy_vad_hangover_unit.sv */
// top level: frame energy voice activity detector with hangover
// a result passes the input, square and accumulate registers after the transaction that ends a frame
// throughput: one sample per cycle unless a result waits on m_tready, set by the square and accumulate stages
// threshold products follow a register write through the square and product registers
// synchronous reset clears the pipeline valids, frame sums and state, and loads the registers with defaults
`default_nettype none
module energy_vad_hangover_unit #(
  parameter int MAX_FRAME   = evh_pkg::MAX_FRAME_DEF,
  parameter int SAMPLE_BITS = evh_pkg::SAMPLE_BITS_DEF,
  parameter int IN_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [IN_W-1:0]                s_tdata,   // sample
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [evh_pkg::OUT_W-1:0]      m_tdata,   // voice_active, detector_state
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [evh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [evh_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
  localparam int SUM_W  = SQ_W + $clog2(MAX_FRAME);
  localparam int PROD_W = 2 * evh_pkg::LVL_W + LEN_W;
  localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  logic [evh_pkg::LVL_W-1:0]  onset_level;
  logic [evh_pkg::LVL_W-1:0]  offset_level;
  logic [evh_pkg::LVL_W-1:0]  recover_level;
  logic [evh_pkg::HLIM_W-1:0] hangover_limit;
  logic [evh_pkg::FLEN_W-1:0] frame_length;

  logic [evh_pkg::FLEN_W-1:0] len_nz;
  logic [LEN_W-1:0]           len_eff;
  logic [PROD_W-1:0]          onset_prod;
  logic [PROD_W-1:0]          offset_prod;
  logic [PROD_W-1:0]          recover_prod;

  logic                       adv;
  logic                       in_valid;
  logic [SAMPLE_BITS-1:0]     in_sample;
  logic                       sq_valid;
  logic [SQ_W-1:0]            sq;
  logic [2*SAMPLE_BITS-1:0]   sq_full;

  logic [SUM_W-1:0]            square_sum;
  logic [evh_pkg::CNT_W-1:0]   sample_count;
  logic [evh_pkg::STATE_W-1:0] vad_state;
  logic [evh_pkg::HCNT_W-1:0]  hangover_count;

  logic [SUM_W-1:0]            sum_new;
  logic [CMP_W-1:0]            sum_cmp;
  logic [evh_pkg::CNT_W-1:0]   count_inc;
  logic                        frame_end;
  logic [evh_pkg::STATE_W-1:0] vad_state_next;
  logic [evh_pkg::HCNT_W-1:0]  hangover_count_next;
  logic                        expired;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      onset_level    <= evh_pkg::ONSET_RST;
      offset_level   <= evh_pkg::OFFSET_RST;
      recover_level  <= evh_pkg::RECOVER_RST;
      hangover_limit <= evh_pkg::HANG_LIM_RST;
      frame_length   <= evh_pkg::FRAME_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        evh_pkg::REG_ONSET:     onset_level    <= cfg_data[evh_pkg::LVL_W-1:0];
        evh_pkg::REG_OFFSET:    offset_level   <= cfg_data[evh_pkg::LVL_W-1:0];
        evh_pkg::REG_RECOVER:   recover_level  <= cfg_data[evh_pkg::LVL_W-1:0];
        evh_pkg::REG_HANG_LIM:  hangover_limit <= cfg_data[evh_pkg::HLIM_W-1:0];
        evh_pkg::REG_FRAME_LEN: frame_length   <= cfg_data[evh_pkg::FLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one sample, clamp to the largest frame
  always_comb begin
    len_nz = (frame_length == '0) ? evh_pkg::FLEN_W'(1) : frame_length;
    if (32'(len_nz) > 32'(MAX_FRAME)) begin
      len_eff = LEN_W'(MAX_FRAME);
    end else begin
      len_eff = LEN_W'(len_nz);
    end
  end

  evh_thresh #(
    .MAX_FRAME (MAX_FRAME),
    .LEN_W     (LEN_W),
    .PROD_W    (PROD_W)
  ) u_thresh (
    .clk           (clk),
    .onset_level   (onset_level),
    .offset_level  (offset_level),
    .recover_level (recover_level),
    .len_eff       (len_eff),
    .onset_prod    (onset_prod),
    .offset_prod   (offset_prod),
    .recover_prod  (recover_prod)
  );

  assign adv      = !(m_tvalid && !m_tready);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= s_tvalid;
      sq_valid <= in_valid;
    end
  end

  assign sq_full = $signed(in_sample) * $signed(in_sample);

  always_ff @(posedge clk) begin
    if (adv) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
      sq        <= sq_full[SQ_W-1:0];
    end
  end

  always_comb begin
    sum_new   = square_sum + SUM_W'(sq);
    sum_cmp   = CMP_W'(sum_new);
    count_inc = (sample_count < evh_pkg::CNT_MAX) ? sample_count + 1'b1 : sample_count;
    frame_end = 32'(count_inc) >= 32'(len_eff);
    expired   = hangover_count > evh_pkg::HCNT_W'(hangover_limit);

    vad_state_next      = vad_state;
    hangover_count_next = hangover_count;
    case (vad_state)
      evh_pkg::ST_SPEECH: begin
        if (sum_cmp < CMP_W'(offset_prod)) begin
          vad_state_next      = evh_pkg::ST_ENDING;
          hangover_count_next = '0;
        end
      end
      evh_pkg::ST_ENDING: begin
        if (sum_cmp > CMP_W'(recover_prod)) begin
          vad_state_next = evh_pkg::ST_SPEECH;
        end else begin
          if (hangover_count < evh_pkg::HCNT_MAX) begin
            hangover_count_next = hangover_count + 1'b1;
          end
          if (expired) begin
            vad_state_next = evh_pkg::ST_SILENCE;
          end
        end
      end
      default: begin
        vad_state_next = evh_pkg::ST_SILENCE;
        if (sum_cmp > CMP_W'(onset_prod)) begin
          vad_state_next = evh_pkg::ST_SPEECH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum     <= '0;
      sample_count   <= '0;
      vad_state      <= evh_pkg::ST_SILENCE;
      hangover_count <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (adv && sq_valid) begin
        if (frame_end) begin
          square_sum     <= '0;
          sample_count   <= '0;
          vad_state      <= vad_state_next;
          hangover_count <= hangover_count_next;
        end else begin
          square_sum   <= sum_new;
          sample_count <= count_inc;
        end
      end
      if (adv && sq_valid && frame_end) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sq_valid && frame_end) begin
      m_tdata <= {{(evh_pkg::OUT_W - evh_pkg::STATE_W - 1){1'b0}}, vad_state_next,
                  (vad_state_next == evh_pkg::ST_SPEECH) ||
                  (vad_state_next == evh_pkg::ST_ENDING)};
    end
  end

endmodule
`default_nettype wire

/* rtl/evh_checker.sv */
// port checker for the voice activity detector, bound to the top level
`default_nettype none
module evh_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [evh_pkg::OUT_W-1:0] m_tdata
);

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed under stall");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered after reset");

  // voice flag agrees with the reported state
  a_voice: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0] == (m_tdata[2:1] != evh_pkg::ST_SILENCE))
    else $error("voice flag does not match state");

  // unused state code never reported
  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:1] != 2'd3)
    else $error("unused state code reported");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[evh_pkg::OUT_W-1:3] == '0)
    else $error("nonzero padding in result");

endmodule

bind energy_vad_hangover_unit evh_checker u_evh_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
